@@ sv/bootloader_frame_receiver_defines.svh @@
// assertion macros shared by the frame receiver modules
// expects clk and arst_n in the scope of the including module
`ifndef BOOTLOADER_FRAME_RECEIVER_DEFINES_SVH
`define BOOTLOADER_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BFR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BFR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/bfr_pkg.sv @@
// shared types, sizes and crc helpers for the bootloader frame receiver
// no dependencies
`default_nettype none

package bfr_pkg;

	localparam int BufferBytes = 4096;
	localparam int TotalW      = 16;
	localparam int CntW        = $clog2(BufferBytes + 1);
	localparam int BankDepth   = (BufferBytes + 1) / 2;
	localparam int RowW        = (BankDepth > 1) ? $clog2(BankDepth) : 1;

	localparam logic [31:0] Crc32Poly = 32'h04C1_1DB7;
	localparam logic [31:0] Crc32Init = 32'hFFFF_FFFF;
	localparam logic [7:0]  Crc8Poly  = 8'h4C;
	localparam logic [7:0]  Crc8Init  = 8'hFF;

	localparam logic CmdByte = 1'b0;
	localparam logic CmdTick = 1'b1;
	localparam logic KindStatus = 1'b0;
	localparam logic KindFlash  = 1'b1;
	localparam logic StatAck  = 1'b0;
	localparam logic StatNack = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} bfr_req_t;

	typedef struct packed {
		logic        kind;
		logic        status;
		logic [31:0] flash_address;
		logic [15:0] halfword;
		logic        done_res;
	} bfr_rsp_t;

	// msb-first crc-32 advanced by one byte
	function automatic logic [31:0] bfr_crc32_byte(logic [31:0] crc, logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {data, 24'h0};
		for (int b = 0; b < 8; b++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ Crc32Poly) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

	// msb-first crc-8 advanced by one byte
	function automatic logic [7:0] bfr_crc8_byte(logic [7:0] crc, logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ Crc8Poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ sv/bfr_byte_ram.sv @@
// one byte-wide simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module bfr_byte_ram #(
	parameter int Depth = 2048,
	parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [7:0]       wdata,
	input  wire logic             re,
	input  wire logic [AddrW-1:0] raddr,
	output      logic [7:0]       rdata
);

	logic [7:0] mem [Depth];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ sv/bootloader_frame_receiver.sv @@
// Write-and-jump frame receiver. Bytes and drain ticks arrive one request per cycle
// while request stall is low; a drain tick that writes a flash halfword reads the even
// and odd byte banks (registered read) before the write leaves the output register,
// and request stall is held high during that read. A pending result that is not taken
// also stalls requests. The data store needs no clearing pass after reset: draining
// only reads bytes of the current frame. The address crc-32 is folded in one byte per
// address byte of the header.
// depends on bfr_pkg, bfr_byte_ram and bootloader_frame_receiver_defines.svh
`default_nettype none

`include "bootloader_frame_receiver_defines.svh"

module bootloader_frame_receiver (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [7:0]        cfg_wdata,
	input  wire logic              req_valid,
	output      logic              req_stall,
	input  wire bfr_pkg::bfr_req_t req,
	output      logic              rsp_valid,
	input  wire logic              rsp_stall,
	output      bfr_pkg::bfr_rsp_t rsp
);

	import bfr_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_COUNT,
		PH_DIGITS,
		PH_DATA,
		PH_DRAIN
	} phase_t;

	phase_t             phase_q;
	logic [7:0]         start_cmd_q;
	logic [2:0]         hdr_cnt_q;
	logic [31:0]        addr_q;
	logic [31:0]        crc32_q;
	logic [31:0]        crc_rx_q;
	logic [7:0]         digits_q;
	logic [TotalW-1:0]  total_q;
	logic [CntW-1:0]    cnt_q;
	logic [7:0]         crc8_q;
	logic [RowW:0]      drain_idx_q;
	logic               rd_pend_q;
	logic [31:0]        wr_addr_s1;
	logic               rsp_valid_q;
	bfr_rsp_t           rsp_q;

	logic               accept;
	logic [7:0]         rx;
	logic [TotalW-1:0]  total_next;
	logic [TotalW-1:0]  pairs;
	logic               drain_more;
	logic               mem_we;
	logic               mem_re;
	logic [7:0]         even_rd;
	logic [7:0]         odd_rd;
	logic [31:0]        crc_rx_next;

	assign req_stall = rd_pend_q | (rsp_valid_q & rsp_stall);
	assign accept    = req_valid & ~req_stall;
	assign rx        = req.rx_byte;

	// n = n*10 + digit, modulo 2^16
	assign total_next = {total_q[TotalW-4:0], 3'b000} + {total_q[TotalW-2:0], 1'b0}
		+ TotalW'(rx);
	assign pairs       = (total_q - TotalW'(1)) >> 1;
	assign drain_more  = TotalW'(drain_idx_q) < pairs;
	assign crc_rx_next = {crc_rx_q[23:0], rx};

	assign mem_we = accept && req.cmd == CmdByte && phase_q == PH_DATA;
	assign mem_re = accept && req.cmd == CmdTick && phase_q == PH_DRAIN && drain_more;

	// byte i lives in bank i[0], row i/2, so one row read gives a whole halfword
	bfr_byte_ram #(.Depth(BankDepth), .AddrW(RowW)) u_even_ram (
		.clk   (clk),
		.we    (mem_we & ~cnt_q[0]),
		.waddr (cnt_q[RowW:1]),
		.wdata (rx),
		.re    (mem_re),
		.raddr (drain_idx_q[RowW-1:0]),
		.rdata (even_rd)
	);

	bfr_byte_ram #(.Depth(BankDepth), .AddrW(RowW)) u_odd_ram (
		.clk   (clk),
		.we    (mem_we & cnt_q[0]),
		.waddr (cnt_q[RowW:1]),
		.wdata (rx),
		.re    (mem_re),
		.raddr (drain_idx_q[RowW-1:0]),
		.rdata (odd_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			start_cmd_q <= '0;
			hdr_cnt_q   <= '0;
			addr_q      <= '0;
			crc32_q     <= Crc32Init;
			crc_rx_q    <= '0;
			digits_q    <= '0;
			total_q     <= '0;
			cnt_q       <= '0;
			crc8_q      <= Crc8Init;
			drain_idx_q <= '0;
			rd_pend_q   <= 1'b0;
			wr_addr_s1  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_we) begin
				start_cmd_q <= cfg_wdata;
			end

			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			// read data arrives in the cycle after the drain tick
			if (rd_pend_q) begin
				rd_pend_q   <= 1'b0;
				rsp_valid_q <= 1'b1;
				rsp_q       <= '{kind: KindFlash, status: StatAck,
					flash_address: wr_addr_s1, halfword: {odd_rd, even_rd}, done_res: 1'b0};
			end

			if (accept) begin
				if (req.cmd == CmdTick) begin
					if (phase_q == PH_DRAIN) begin
						if (drain_more) begin
							rd_pend_q   <= 1'b1;
							wr_addr_s1  <= addr_q + 32'({drain_idx_q, 1'b0});
							drain_idx_q <= drain_idx_q + 1'b1;
						end else begin
							phase_q     <= PH_IDLE;
							rsp_valid_q <= 1'b1;
							rsp_q       <= '{kind: KindStatus, status: StatAck,
								flash_address: addr_q, halfword: 16'h0, done_res: 1'b1};
						end
					end
				end else begin
					case (phase_q)
						PH_IDLE: begin
							if (rx == start_cmd_q) begin
								phase_q   <= PH_HEADER;
								hdr_cnt_q <= '0;
								crc32_q   <= Crc32Init;
							end
						end
						PH_HEADER: begin
							hdr_cnt_q <= hdr_cnt_q + 1'b1;
							if (!hdr_cnt_q[2]) begin
								addr_q  <= {addr_q[23:0], rx};
								crc32_q <= bfr_crc32_byte(crc32_q, rx);
							end else begin
								crc_rx_q <= crc_rx_next;
							end
							if (hdr_cnt_q == 3'd7) begin
								if (crc_rx_next != crc32_q) begin
									phase_q     <= PH_IDLE;
									rsp_valid_q <= 1'b1;
									rsp_q       <= '{kind: KindStatus, status: StatNack,
										flash_address: 32'h0, halfword: 16'h0, done_res: 1'b0};
								end else begin
									phase_q <= PH_COUNT;
								end
							end
						end
						PH_COUNT: begin
							digits_q <= rx;
							total_q  <= '0;
							if (rx == 8'h00) begin
								phase_q     <= PH_IDLE;
								rsp_valid_q <= 1'b1;
								rsp_q       <= '{kind: KindStatus, status: StatNack,
									flash_address: 32'h0, halfword: 16'h0, done_res: 1'b0};
							end else begin
								phase_q <= PH_DIGITS;
							end
						end
						PH_DIGITS: begin
							total_q  <= total_next;
							digits_q <= digits_q - 1'b1;
							if (digits_q == 8'd1) begin
								if (total_next == '0 || total_next > TotalW'(BufferBytes)) begin
									phase_q     <= PH_IDLE;
									rsp_valid_q <= 1'b1;
									rsp_q       <= '{kind: KindStatus, status: StatNack,
										flash_address: 32'h0, halfword: 16'h0, done_res: 1'b0};
								end else begin
									phase_q <= PH_DATA;
									cnt_q   <= '0;
									crc8_q  <= Crc8Init;
								end
							end
						end
						PH_DATA: begin
							if (TotalW'(cnt_q) + TotalW'(1) < total_q) begin
								crc8_q <= bfr_crc8_byte(crc8_q, rx);
								cnt_q  <= cnt_q + 1'b1;
							end else begin
								// last byte is the check byte
								rsp_valid_q <= 1'b1;
								if (crc8_q == rx) begin
									phase_q     <= PH_DRAIN;
									drain_idx_q <= '0;
									rsp_q       <= '{kind: KindStatus, status: StatAck,
										flash_address: 32'h0, halfword: 16'h0, done_res: 1'b0};
								end else begin
									phase_q <= PH_IDLE;
									rsp_q   <= '{kind: KindStatus, status: StatNack,
										flash_address: 32'h0, halfword: 16'h0, done_res: 1'b0};
								end
							end
						end
						default: begin
							if (phase_q != PH_DRAIN) begin
								phase_q <= PH_IDLE;
							end
						end
					endcase
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BFR_ASSERT_IMP(a_read_blocks_req, rd_pend_q, req_stall, "request taken during bank read")
	`BFR_ASSERT_NXT(a_read_gives_rsp, rd_pend_q, rsp_valid_q && rsp_q.kind == KindFlash,
		"bank read did not produce a flash write")
	`BFR_ASSERT_IMP(a_read_in_drain, rd_pend_q, phase_q == PH_DRAIN,
		"bank read outside draining")
	`BFR_ASSERT_IMP(a_drain_bound, phase_q == PH_DRAIN, TotalW'(drain_idx_q) <= pairs,
		"drain index ran past the halfword count")
	`BFR_ASSERT_IMP(a_data_in_range, phase_q == PH_DATA, TotalW'(cnt_q) < total_q,
		"data byte index past frame length")

endmodule

`default_nettype wire

@@ test/bfr_frame_checker.sv @@
// frame checker for the bootloader frame receiver: watches both channels,
// predicts every result from the accepted requests and compares them in order
// depends on bfr_pkg
`default_nettype none

module bfr_frame_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [7:0]        cfg_wdata,
	input  wire logic              req_valid,
	input  wire logic              req_stall,
	input  wire bfr_pkg::bfr_req_t req,
	input  wire logic              rsp_valid,
	input  wire logic              rsp_stall,
	input  wire bfr_pkg::bfr_rsp_t rsp,
	output int                     errors,
	output int                     pending
);

	import bfr_pkg::*;

	typedef enum logic [2:0] {
		AWAIT_CMD,
		GET_HEADER,
		GET_COUNT,
		GET_DIGITS,
		GET_DATA,
		DRAINING
	} frame_phase_t;

	frame_phase_t phase;
	logic [7:0]   start_cmd;
	logic [63:0]  header;
	logic [15:0]  rx_count;
	logic [15:0]  frame_len;
	logic [15:0]  drain_idx;
	logic [7:0]   digits_left;
	logic [7:0]   data_crc;
	logic [7:0]   frame_bytes [BufferBytes];
	bfr_rsp_t     expected_out[$];

	// crc-32 of the address word, msb first, init all ones
	function automatic logic [31:0] address_crc(input logic [31:0] word);
		logic [31:0] c;
		c = ~word;
		for (int i = 0; i < 32; i++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ Crc32Poly) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] payload_crc(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ Crc8Poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	task automatic queue_status(input logic st, input logic [31:0] a, input logic done);
		bfr_rsp_t e;
		e = '0;
		e.kind = KindStatus;
		e.status = st;
		e.flash_address = a;
		e.done_res = done;
		expected_out.push_back(e);
	endtask

	task automatic reject_frame();
		phase = AWAIT_CMD;
		queue_status(StatNack, 32'd0, 1'b0);
	endtask

	task automatic predict_request(input bfr_req_t r);
		bfr_rsp_t   e;
		logic [15:0] pairs;
		e = '0;
		if (r.cmd == CmdTick) begin
			if (phase == DRAINING) begin
				pairs = (frame_len - 16'd1) >> 1;
				if (drain_idx < pairs) begin
					e.kind = KindFlash;
					e.status = StatAck;
					e.flash_address = header[63:32] + {15'd0, drain_idx, 1'b0};
					e.halfword = {frame_bytes[2 * int'(drain_idx) + 1],
						frame_bytes[2 * int'(drain_idx)]};
					expected_out.push_back(e);
					drain_idx = drain_idx + 16'd1;
				end else begin
					// last tick: jump to the frame address
					phase = AWAIT_CMD;
					queue_status(StatAck, header[63:32], 1'b1);
				end
			end
		end else begin
			case (phase)
				AWAIT_CMD: begin
					if (r.rx_byte == start_cmd) begin
						phase = GET_HEADER;
						rx_count = '0;
						header = '0;
					end
				end
				GET_HEADER: begin
					header = {header[55:0], r.rx_byte};
					rx_count = rx_count + 16'd1;
					if (rx_count == 16'd8) begin
						if (address_crc(header[63:32]) != header[31:0])
							reject_frame();
						else
							phase = GET_COUNT;
					end
				end
				GET_COUNT: begin
					digits_left = r.rx_byte;
					frame_len = '0;
					if (digits_left == 8'd0)
						reject_frame();
					else
						phase = GET_DIGITS;
				end
				GET_DIGITS: begin
					frame_len = frame_len * 16'd10 + {8'd0, r.rx_byte};
					digits_left = digits_left - 8'd1;
					if (digits_left == 8'd0) begin
						if (frame_len == 16'd0 || int'(frame_len) > BufferBytes) begin
							reject_frame();
						end else begin
							phase = GET_DATA;
							rx_count = '0;
							data_crc = Crc8Init;
						end
					end
				end
				GET_DATA: begin
					frame_bytes[int'(rx_count)] = r.rx_byte;
					if (int'(rx_count) + 1 < int'(frame_len)) begin
						data_crc = payload_crc(data_crc, r.rx_byte);
						rx_count = rx_count + 16'd1;
					end else if (data_crc != r.rx_byte) begin
						reject_frame();
					end else begin
						phase = DRAINING;
						drain_idx = '0;
						queue_status(StatAck, 32'd0, 1'b0);
					end
				end
				default: begin
					// bytes during draining are dropped
				end
			endcase
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bfr_rsp_t want;
		if (!arst_n) begin
			errors = 0;
			pending <= 0;
			start_cmd = 8'd0;
			phase = AWAIT_CMD;
			header = '0;
			rx_count = '0;
			frame_len = '0;
			drain_idx = '0;
			digits_left = '0;
			data_crc = Crc8Init;
			expected_out.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_out.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, expected none actual %h",
						$time, rsp);
				end else begin
					want = expected_out.pop_front();
					check_field("kind", 32'(want.kind), 32'(rsp.kind));
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("flash_address", want.flash_address, rsp.flash_address);
					check_field("halfword", 32'(want.halfword), 32'(rsp.halfword));
					check_field("done_res", 32'(want.done_res), 32'(rsp.done_res));
				end
			end
			if (cfg_we)
				start_cmd = cfg_wdata;
			if (req_valid && !req_stall)
				predict_request(req);
			pending <= expected_out.size();
		end
	end

endmodule

`default_nettype wire

@@ test/tb_bootloader_frame_receiver.sv @@
// testbench top for the bootloader frame receiver: clock, reset, frame stimulus,
// receiver stall pattern and the verdict
// depends on bfr_pkg, bootloader_frame_receiver and bfr_frame_checker
`default_nettype none

module tb_bootloader_frame_receiver;

	import bfr_pkg::*;

	typedef logic [7:0] digit_q_t[$];

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	bfr_req_t   req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	bfr_rsp_t   rsp;
	int         fail_count;
	int         pending;

	int         items_sent = 0;
	int         burst_left = 0;
	bit         steady = 1'b0;
	logic [7:0] start_cmd = 8'd0;

	int         stall_left = 0;
	int         stall_mode = 0;
	logic [3:0] stall_phase = 4'd0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	bootloader_frame_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	bfr_frame_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.errors    (fail_count),
		.pending   (pending)
	);

	// receiver back-pressure: a new random mode is drawn whenever its countdown runs out
	always @(negedge clk) begin
		stall_phase <= stall_phase + 4'd1;
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(16, 160);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= 1'($urandom_range(0, 1));
			default: rsp_stall <= stall_phase[3];
		endcase
	end

	// one request, with bursts and random gaps unless running steady
	task automatic push_request(input logic c, input logic [7:0] b);
		int gap;
		@(negedge clk);
		if (!steady && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		req_valid <= 1'b1;
		req.cmd <= c;
		req.rx_byte <= b;
		do @(posedge clk); while (req_stall);
		items_sent++;
	endtask

	// frame byte, now and then preceded by a stray drain tick that must be ignored
	task automatic frame_byte(input logic [7:0] b);
		if ($urandom_range(0, 39) == 0)
			push_request(CmdTick, 8'($urandom_range(0, 255)));
		push_request(CmdByte, b);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_start_cmd(input logic [7:0] value);
		pause_until_drained();
		// a drain tick holds a bank read in flight, let the block settle
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		start_cmd = value;
	endtask

	function automatic digit_q_t decimal_digits(input int unsigned n, input int zeros);
		digit_q_t d;
		do begin
			d.push_front(8'(n % 10));
			n = n / 10;
		end while (n != 0);
		repeat (zeros) d.push_front(8'd0);
		return d;
	endfunction

	task automatic send_frame(input logic [31:0] addr, input bit hdr_good,
		input digit_q_t digs, input bit data_good);
		logic [31:0] crc;
		logic [15:0] len;
		logic [7:0]  chk;
		logic [7:0]  b;
		int          npairs;
		push_request(CmdByte, start_cmd);
		crc = Crc32Init;
		for (int i = 0; i < 4; i++)
			crc = bfr_crc32_byte(crc, addr[31 - 8 * i -: 8]);
		if (!hdr_good)
			crc = crc ^ (32'd1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			frame_byte(addr[31 - 8 * i -: 8]);
		for (int i = 0; i < 4; i++)
			frame_byte(crc[31 - 8 * i -: 8]);
		if (!hdr_good)
			return;
		frame_byte(8'(digs.size()));
		len = '0;
		foreach (digs[i]) begin
			frame_byte(digs[i]);
			len = len * 16'd10 + {8'd0, digs[i]};
		end
		if (len == 16'd0 || int'(len) > BufferBytes)
			return;
		chk = Crc8Init;
		for (int i = 0; i < int'(len) - 1; i++) begin
			b = 8'($urandom_range(0, 255));
			chk = bfr_crc8_byte(chk, b);
			frame_byte(b);
		end
		if (!data_good)
			chk = chk ^ 8'($urandom_range(1, 255));
		frame_byte(chk);
		if (!data_good)
			return;
		npairs = (int'(len) - 1) / 2;
		for (int i = 0; i <= npairs; i++) begin
			// bytes arriving while draining are dropped
			if ($urandom_range(0, 29) == 0)
				push_request(CmdByte, 8'($urandom_range(0, 255)));
			push_request(CmdTick, 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 9) == 0)
			push_request(CmdTick, 8'($urandom_range(0, 255)));
	endtask

	task automatic random_frame();
		digit_q_t    digs;
		int          sel;
		int unsigned n;
		logic [31:0] addr;
		bit          hdr_good;
		bit          data_good;
		sel = $urandom_range(0, 99);
		hdr_good = 1'b1;
		data_good = 1'b1;
		case ($urandom_range(0, 9))
			0: addr = 32'h0000_0000;
			1: addr = 32'hFFFF_FFFF;
			2: addr = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
			default: addr = $urandom;
		endcase
		digs = decimal_digits(1, 0);
		if (sel < 6) begin
			hdr_good = 1'b0;
		end else if (sel < 10) begin
			digs.delete();
		end else if (sel < 14) begin
			digs = decimal_digits(0, $urandom_range(0, 2));
		end else if (sel < 19) begin
			// too long, or wrapping past 16 bits
			case ($urandom_range(0, 3))
				0: n = BufferBytes + 1;
				1: n = 65536;
				2: n = 65537;
				default: n = $urandom_range(BufferBytes + 1, 65535);
			endcase
			digs = decimal_digits(n, 0);
		end else if (sel < 23) begin
			// digit values above nine are taken as they come
			digs.delete();
			if ($urandom_range(0, 1))
				digs.push_back(8'($urandom_range(0, 2)));
			digs.push_back(8'($urandom_range(10, 255)));
			data_good = ($urandom_range(0, 3) != 0);
		end else begin
			case ($urandom_range(0, 19))
				0: n = $urandom_range(65, 300);
				1, 2, 3, 4, 5: n = $urandom_range(13, 64);
				default: n = $urandom_range(1, 12);
			endcase
			digs = decimal_digits(n, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
			data_good = (sel >= 31);
		end
		send_frame(addr, hdr_good, digs, data_good);
	endtask

	task automatic idle_noise();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0: begin
				repeat ($urandom_range(1, 3)) begin
					b = 8'($urandom_range(0, 255));
					if (b == start_cmd)
						b = ~b;
					push_request(CmdByte, b);
				end
			end
			1: push_request(CmdTick, 8'($urandom_range(0, 255)));
			default: begin
			end
		endcase
	endtask

	initial begin
		logic [7:0] cmd_values [5];
		int         goal;
		cmd_values[0] = 8'h00;
		cmd_values[1] = 8'hFF;
		cmd_values[2] = 8'hA5;
		cmd_values[3] = 8'($urandom_range(0, 255));
		cmd_values[4] = 8'($urandom_range(0, 255));
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 5; p++) begin
			write_start_cmd(cmd_values[p]);
			if (p == 0) begin
				// ignored tick and byte while idle, one-byte frame, broken header
				push_request(CmdTick, 8'hFF);
				push_request(CmdByte, ~start_cmd);
				send_frame(32'hFFFF_FFFF, 1'b1, decimal_digits(1, 0), 1'b1);
				send_frame(32'h0000_0000, 1'b0, decimal_digits(1, 0), 1'b1);
			end
			goal = items_sent + 350;
			while (items_sent < goal) begin
				steady = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 14) == 0)
					pause_until_drained();
				idle_noise();
				random_frame();
			end
			steady = 1'b0;
		end
		pause_until_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("** bootloader_frame_receiver: PASSED **");
		else
			$display("** bootloader_frame_receiver: FAILED **");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("** bootloader_frame_receiver: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

@@ bootloader_frame_receiver.f @@
+incdir+sv
sv/bfr_pkg.sv
sv/bfr_byte_ram.sv
sv/bootloader_frame_receiver.sv
test/bfr_frame_checker.sv
test/tb_bootloader_frame_receiver.sv
